[hw/rtl/ffha_pkg.sv]
// ffha_pkg: shared types and constants of the first-fit heap allocator
// used by ffha_cell and first_fit_heap_allocator; no dependencies
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int HEAP_BYTES_DEF   = 1048576;
  localparam int HEADER_BYTES_DEF = 16;

  localparam int AddrW  = 20;
  localparam int SizeW  = 21;
  localparam int PosW   = 10;
  localparam int WideW  = 25;

  localparam logic [SizeW-1:0] LIMIT_RESET = 21'd1048576;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOHEAP  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [SizeW-1:0] size;
    logic             free;
  } seg_t;

  typedef struct packed {
    logic             operation;
    logic [SizeW-1:0] request_size;
    logic [AddrW-1:0] release_address;
  } in_t;

  typedef struct packed {
    logic [AddrW-1:0] data_address;
    logic [2:0]       status;
  } out_t;

  // update broadcast to every cell
  typedef struct packed {
    logic            wa_en;
    logic [PosW-1:0] wa_pos;
    seg_t            wa_seg;
    logic            wb_en;
    logic [PosW-1:0] wb_pos;
    seg_t            wb_seg;
    logic            shr_en;
    logic            shl_en;
    logic [PosW-1:0] sh_pos;
  } cmd_t;

endpackage

[hw/rtl/ffha_cell.sv]
// ffha_cell: one table slot of the allocator, holds one segment
// depends on ffha_pkg; takes the entry of its left or right neighbor on a shift
`timescale 1ns / 1ps

module ffha_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                          clk_i,
  input  ffha_pkg::seg_t                left_i,
  input  ffha_pkg::seg_t                right_i,
  input  ffha_pkg::cmd_t                cmd_i,
  input  logic [CW-1:0]                 count_i,
  input  logic [ffha_pkg::SizeW-1:0]    req_i,
  input  logic [ffha_pkg::AddrW-1:0]    addr_i,
  input  logic [ffha_pkg::AddrW-1:0]    header_i,
  output ffha_pkg::seg_t                seg_o,
  output logic                          fit_o,
  output logic                          match_o
);

  localparam logic [ffha_pkg::PosW-1:0] MyPos = ffha_pkg::PosW'(IDX);

  ffha_pkg::seg_t seg_q, seg_d;
  logic           valid;

  assign valid = CW'(IDX) < count_i;

  always_comb begin
    seg_d = seg_q;
    if (cmd_i.wa_en && cmd_i.wa_pos == MyPos) begin
      seg_d = cmd_i.wa_seg;
    end else if (cmd_i.wb_en && cmd_i.wb_pos == MyPos) begin
      seg_d = cmd_i.wb_seg;
    end else if (cmd_i.shr_en && MyPos > cmd_i.sh_pos) begin
      seg_d = left_i;
    end else if (cmd_i.shl_en && MyPos >= cmd_i.sh_pos) begin
      seg_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
  end

  assign seg_o   = seg_q;
  assign fit_o   = valid && seg_q.free && (seg_q.size >= req_i);
  assign match_o = valid && ((seg_q.start + header_i) == addr_i);

endmodule

[hw/rtl/ffha_pick.sv]
// ffha_pick: lowest-index priority pick over the cell flags
// depends on nothing but its parameters
`timescale 1ns / 1ps

module ffha_pick #(
  parameter int N  = 64,
  parameter int IW = 6
) (
  input  logic [N-1:0]  vec_i,
  output logic          hit_o,
  output logic [IW-1:0] idx_o
);

  always_comb begin
    idx_o = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (vec_i[k]) begin
        idx_o = IW'(k);
      end
    end
  end

  assign hit_o = |vec_i;

endmodule

[hw/rtl/first_fit_heap_allocator.sv]
// first_fit_heap_allocator: first-fit heap allocator with coalescing
// holds a row of ffha_cell slots and a sequencer; depends on ffha_pkg,
// ffha_cell and ffha_pick
//
// usage:
//   input channel in_valid_i / in_stall_o / in_data_i carries one request:
//   an allocate of request_size bytes or a free of release_address.
//   output channel out_valid_o / out_stall_i / out_data_o returns one
//   transaction per request: data_address and status.
//   cfg_we_i / cfg_wdata_i writes heap_limit; write it only while idle (the block does not enforce this).
// timing:
//   after a request is accepted, S_SCAN scans all cells and registers the
//   pick, then the update state S_EXEC writes the table and registers the
//   result. the next request is taken only once the sequencer is back in
//   S_IDLE; a free that merges with both neighbors first passes S_SHIFT2,
//   where the table closes a second time by a shift along the cell row.
//   the update state waits while a previous result is still stalled.
// reset:
//   rst_ni clears the segment count, heap end and heap_limit (1048576);
//   no clearing pass, cells beyond the count are never looked at.
`timescale 1ns / 1ps

module first_fit_heap_allocator #(
  parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF,
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ffha_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ffha_pkg::out_t             out_data_o,
  input  logic                       cfg_we_i,
  input  logic [ffha_pkg::SizeW-1:0] cfg_wdata_i
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int AW = ffha_pkg::AddrW;
  localparam int SW = ffha_pkg::SizeW;
  localparam int WW = ffha_pkg::WideW;
  localparam int PW = ffha_pkg::PosW;

  localparam logic [AW-1:0] HdrA = AW'(HEADER_BYTES);
  localparam logic [SW-1:0] HdrS = SW'(HEADER_BYTES);
  localparam logic [WW-1:0] HdrW = WW'(HEADER_BYTES);
  localparam logic [WW-1:0] HeapW = WW'(HEAP_BYTES);
  localparam logic [CW-1:0] MaxC = CW'(MAX_SEGMENTS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_EXEC   = 2'd2;
  localparam logic [1:0] S_SHIFT2 = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [SW-1:0]        heap_end_q, heap_end_d;
  logic [SW-1:0]        limit_q;
  ffha_pkg::in_t        req_q;
  ffha_pkg::out_t       out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic [IW-1:0]        sh2_pos_q, sh2_pos_d;

  // scan results
  logic                 hit_q;
  logic [IW-1:0]        idx_q;
  ffha_pkg::seg_t       sel_q, prev_q, next_q;
  logic                 prev_ok_q, next_ok_q;

  ffha_pkg::seg_t       segs [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] fit_vec, match_vec;
  ffha_pkg::cmd_t       cmd;

  logic                 hit;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        idx_m1, idx_p1;

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    ffha_cell #(
      .IDX(k),
      .CW (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .left_i  (segs[(k > 0) ? k - 1 : k]),
      .right_i (segs[(k < MAX_SEGMENTS - 1) ? k + 1 : k]),
      .cmd_i   (cmd),
      .count_i (count_q),
      .req_i   (req_q.request_size),
      .addr_i  (req_q.release_address),
      .header_i(HdrA),
      .seg_o   (segs[k]),
      .fit_o   (fit_vec[k]),
      .match_o (match_vec[k])
    );
  end

  ffha_pick #(
    .N (MAX_SEGMENTS),
    .IW(IW)
  ) u_pick (
    .vec_i((req_q.operation == ffha_pkg::OP_FREE) ? match_vec : fit_vec),
    .hit_o(hit),
    .idx_o(idx)
  );

  assign idx_m1 = idx - IW'(1);
  assign idx_p1 = idx + IW'(1);

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q <= in_data_i;
    end
    if (state_q == S_SCAN) begin
      hit_q     <= hit;
      idx_q     <= idx;
      sel_q     <= segs[idx];
      prev_q    <= segs[idx_m1];
      next_q    <= segs[idx_p1];
      prev_ok_q <= (idx != '0) && segs[idx_m1].free;
      next_ok_q <= ((CW'(idx) + CW'(1)) < count_q) && segs[idx_p1].free;
    end
    out_q <= out_d;
  end

  // update decision
  logic                 go;
  logic [WW-1:0]        req_w, size_w, end_w, limit_w;
  logic [SW-1:0]        merged;
  logic [PW-1:0]        pos, pos_m1, pos_p1;

  assign go      = !(out_valid_q && out_stall_i);
  assign req_w   = WW'(req_q.request_size);
  assign size_w  = WW'(sel_q.size);
  assign end_w   = WW'(heap_end_q) + HdrW + req_w;
  assign limit_w = (WW'(limit_q) < HeapW) ? WW'(limit_q) : HeapW;
  assign pos     = PW'(idx_q);
  assign pos_m1  = pos - PW'(1);
  assign pos_p1  = pos + PW'(1);

  always_comb begin
    merged = sel_q.size;
    if (prev_ok_q) begin
      merged = merged + HdrS + prev_q.size;
    end
    if (next_ok_q) begin
      merged = merged + HdrS + next_q.size;
    end
  end

  always_comb begin
    cmd          = '0;
    state_d      = state_q;
    count_d      = count_q;
    heap_end_d   = heap_end_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    sh2_pos_d    = sh2_pos_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (go) begin
          state_d      = S_IDLE;
          out_valid_d  = 1'b1;
          out_d.data_address = '0;
          out_d.status       = ffha_pkg::ST_OK;
          if (req_q.operation == ffha_pkg::OP_ALLOC) begin
            if (req_q.request_size == '0) begin
              out_d.status = ffha_pkg::ST_ZERO;
            end else if (hit_q) begin
              if (size_w > req_w + HdrW) begin
                if (count_q >= MaxC) begin
                  out_d.status = ffha_pkg::ST_FULL;
                end else begin
                  cmd.wa_en        = 1'b1;
                  cmd.wa_pos       = pos;
                  cmd.wa_seg.start = sel_q.start;
                  cmd.wa_seg.size  = req_q.request_size;
                  cmd.wa_seg.free  = 1'b0;
                  cmd.wb_en        = 1'b1;
                  cmd.wb_pos       = pos_p1;
                  cmd.wb_seg.start = sel_q.start + HdrA + AW'(req_q.request_size);
                  cmd.wb_seg.size  = sel_q.size - req_q.request_size - HdrS;
                  cmd.wb_seg.free  = 1'b1;
                  cmd.shr_en       = 1'b1;
                  cmd.sh_pos       = pos_p1;
                  count_d          = count_q + CW'(1);
                  out_d.data_address = sel_q.start + HdrA;
                end
              end else begin
                cmd.wa_en       = 1'b1;
                cmd.wa_pos      = pos;
                cmd.wa_seg      = sel_q;
                cmd.wa_seg.free = 1'b0;
                out_d.data_address = sel_q.start + HdrA;
              end
            end else if (count_q >= MaxC) begin
              out_d.status = ffha_pkg::ST_FULL;
            end else if (end_w > limit_w) begin
              out_d.status = ffha_pkg::ST_NOHEAP;
            end else begin
              cmd.wa_en        = 1'b1;
              cmd.wa_pos       = PW'(count_q);
              cmd.wa_seg.start = heap_end_q[AW-1:0];
              cmd.wa_seg.size  = req_q.request_size;
              cmd.wa_seg.free  = 1'b0;
              count_d          = count_q + CW'(1);
              heap_end_d       = end_w[SW-1:0];
              out_d.data_address = heap_end_q[AW-1:0] + HdrA;
            end
          end else if (req_q.release_address == '0) begin
            out_d.status = ffha_pkg::ST_OK;
          end else if (!hit_q || sel_q.free) begin
            out_d.status = ffha_pkg::ST_UNKNOWN;
          end else begin
            cmd.wa_en       = 1'b1;
            cmd.wa_seg.size = merged;
            cmd.wa_seg.free = 1'b1;
            if (prev_ok_q) begin
              cmd.wa_pos       = pos_m1;
              cmd.wa_seg.start = prev_q.start;
              cmd.shl_en       = 1'b1;
              cmd.sh_pos       = pos;
              count_d          = count_q - CW'(1);
              if (next_ok_q) begin
                // both neighbors free: second close at the same slot
                count_d   = count_q - CW'(2);
                sh2_pos_d = idx_q;
                state_d   = S_SHIFT2;
              end
            end else begin
              cmd.wa_pos       = pos;
              cmd.wa_seg.start = sel_q.start;
              if (next_ok_q) begin
                cmd.shl_en = 1'b1;
                cmd.sh_pos = pos_p1;
                count_d    = count_q - CW'(1);
              end
            end
          end
        end
      end
      S_SHIFT2: begin
        cmd.shl_en = 1'b1;
        cmd.sh_pos = PW'(sh2_pos_q);
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      heap_end_q  <= '0;
      limit_q     <= ffha_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
      sh2_pos_q   <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      heap_end_q  <= heap_end_d;
      out_valid_q <= out_valid_d;
      sh2_pos_q   <= sh2_pos_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxC)
    else $error("segment count above table size");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_SCAN))
    else $error("accepted transaction not scanned");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_EXEC))
    else $error("result raised outside update cycle");
`endif

endmodule
